// ----- hdl/sjr_pkg.sv -----
// shared types, constants and helpers for the survival jump recursion block
package sjr_pkg;

  // fixed point and word widths
  localparam int unsigned FRAC_BITS_DEF = 32;
  localparam int unsigned WORD_W        = 48;
  localparam int unsigned DIV_W         = 64;
  localparam int unsigned QUO_W         = WORD_W - 1;
  localparam int unsigned CNT_W         = 16;
  localparam int unsigned IN_DATA_W     = 32;
  localparam int unsigned OUT_DATA_W    = 2 * WORD_W;

  // saturation limits, as 48-bit words and as 64-bit words
  localparam logic signed [WORD_W-1:0] W48_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [WORD_W-1:0] W48_MIN = 48'sh8000_0000_0000;
  localparam logic signed [DIV_W-1:0]  W64_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [DIV_W-1:0]  W64_MIN = 64'shFFFF_8000_0000_0000;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_WSTART,
    ST_WWAIT,
    ST_SURV,
    ST_ASTART,
    ST_AWAIT,
    ST_FINISH
  } sjr_state_e;

  // status from the shared reciprocal unit
  typedef struct packed {
    logic done;
    logic fault;
  } sjr_recip_stat_t;

  // clamp a 64-bit signed value to the 48-bit signed range
  function automatic logic signed [WORD_W-1:0] sat48(input logic signed [DIV_W-1:0] v);
    logic signed [WORD_W-1:0] r;
    if (v > W64_MAX) begin
      r = W48_MAX;
    end else if (v < W64_MIN) begin
      r = W48_MIN;
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- hdl/kmc_survival_jump_recursion_top.sv -----
// top level: sequencer, recursion state and output register around the reciprocal unit
//
// Takes one sample per beat (tuser = observed flag, tdata = Q16.16 constraint value) and
// returns one beat with the jump weight and survival value in
// Q(48-FRAC_BITS).FRAC_BITS, a divide fault flag in tuser and tlast on the final
// sample of a set. All reciprocals go through one restoring divider that produces one
// quotient bit per cycle over 2*FRAC_BITS+1 steps (a zero divisor finishes at once).
// An observed sample, or a censored one after the first, needs one division; a
// censored first sample needs two. Input is refused while a sample is in work; a
// finished result sits in the output register so the next sample can be taken while
// it waits, and a sample stalls at its end while that register is still full.
// sample_count may be written only while idle.
module kmc_survival_jump_recursion_top #(
  parameter int unsigned FRAC_BITS = sjr_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration: sample_count
  input  logic                               cfg_we_i,
  input  logic [sjr_pkg::CNT_W-1:0]          cfg_wdata_i,
  // sample input
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [sjr_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,   // [31:0] constraint_value
  input  logic                               s_axis_tuser_i,   // [0] observed
  // result output
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [sjr_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,   // [47:0] jump_weight,
                                                               // [95:48] survival
  output logic                               m_axis_tuser_o,   // [0] divide_fault
  output logic                               m_axis_tlast_o
);

  localparam int unsigned W  = sjr_pkg::WORD_W;
  localparam int unsigned DW = sjr_pkg::DIV_W;
  localparam logic signed [DW-1:0] ONE = 64'sd1 <<< FRAC_BITS;

  sjr_pkg::sjr_state_e state_q, state_d;

  // recursion state and configuration
  logic [sjr_pkg::CNT_W-1:0] count_q;
  logic [sjr_pkg::CNT_W-1:0] idx_q;
  logic signed [W-1:0]       prev_q;
  logic signed [W-1:0]       acc_q;

  // per-sample work registers
  logic                      obs_q;
  logic                      first_q;
  logic                      last_q;
  logic                      fault_q;
  logic signed [DW-1:0]      base_q;
  logic signed [DW-1:0]      div_q;
  logic signed [W-1:0]       w_q;
  logic signed [W-1:0]       s_q;

  // output register
  logic                      m_valid_q;
  logic [sjr_pkg::OUT_DATA_W-1:0] m_data_q;
  logic                      m_user_q;
  logic                      m_last_q;

  // reciprocal unit link
  logic                      recip_start;
  logic signed [W-1:0]       recip_q;
  sjr_pkg::sjr_recip_stat_t  recip_stat;

  // combinational helpers
  logic                      in_acc;
  logic                      out_free;
  logic [sjr_pkg::CNT_W-1:0] n_eff;
  logic signed [DW-1:0]      nq;
  logic signed [DW-1:0]      g_sc;
  logic signed [DW-1:0]      surv_base;
  logic signed [W-1:0]       w_out;

  assign in_acc   = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free = ~m_valid_q | m_axis_tready_i;

  // n and constraint value scaled to FRAC_BITS, survival base, clamped last weight
  always_comb begin
    n_eff     = (count_q == '0) ? sjr_pkg::CNT_W'(1) : count_q;
    nq        = $signed(DW'(n_eff)) <<< FRAC_BITS;
    g_sc      = DW'($signed(s_axis_tdata_i)) <<< (FRAC_BITS - 16);
    surv_base = first_q ? ONE : DW'(prev_q);
    w_out     = (last_q && w_q[W-1]) ? '0 : w_q;
  end

  sjr_recip #(
    .FRAC_BITS (FRAC_BITS)
  ) u_recip (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (recip_start),
    .divisor_i  (div_q),
    .quotient_o (recip_q),
    .stat_o     (recip_stat)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sjr_pkg::ST_IDLE:   if (s_axis_tvalid_i) state_d = sjr_pkg::ST_PREP;
      sjr_pkg::ST_PREP: begin
        state_d = (first_q || obs_q) ? sjr_pkg::ST_WSTART : sjr_pkg::ST_SURV;
      end
      sjr_pkg::ST_WSTART: state_d = sjr_pkg::ST_WWAIT;
      sjr_pkg::ST_WWAIT:  if (recip_stat.done) state_d = sjr_pkg::ST_SURV;
      sjr_pkg::ST_SURV: begin
        state_d = obs_q ? sjr_pkg::ST_FINISH : sjr_pkg::ST_ASTART;
      end
      sjr_pkg::ST_ASTART: state_d = sjr_pkg::ST_AWAIT;
      sjr_pkg::ST_AWAIT:  if (recip_stat.done) state_d = sjr_pkg::ST_FINISH;
      sjr_pkg::ST_FINISH: if (out_free) state_d = sjr_pkg::ST_IDLE;
      default:            state_d = sjr_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready_o = (state_q == sjr_pkg::ST_IDLE);
    recip_start     = (state_q == sjr_pkg::ST_WSTART) || (state_q == sjr_pkg::ST_ASTART);
  end

  // state, configuration and recursion registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sjr_pkg::ST_IDLE;
      count_q   <= sjr_pkg::CNT_W'(1);
      idx_q     <= '0;
      prev_q    <= '0;
      acc_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      // a first sample restarts the sum; a censored one then adds its own term
      if (state_q == sjr_pkg::ST_SURV && first_q) begin
        acc_q <= '0;
      end
      if (state_q == sjr_pkg::ST_AWAIT && recip_stat.done) begin
        acc_q <= sjr_pkg::sat48(DW'(acc_q) + DW'(recip_q));
      end
      if (state_q == sjr_pkg::ST_FINISH && out_free) begin
        prev_q    <= s_q;
        idx_q     <= last_q ? '0 : idx_q + 1'b1;
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // per-sample datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      sjr_pkg::ST_IDLE: begin
        if (in_acc) begin
          obs_q   <= s_axis_tuser_i;
          first_q <= (idx_q == '0);
          last_q  <= (idx_q >= n_eff - 1'b1);
          fault_q <= 1'b0;
          base_q  <= nq - g_sc;
        end
      end
      sjr_pkg::ST_PREP: begin
        div_q <= first_q ? base_q : base_q - DW'(acc_q);
        w_q   <= '0;
      end
      sjr_pkg::ST_WWAIT: begin
        if (recip_stat.done) begin
          w_q     <= recip_q;
          fault_q <= fault_q | recip_stat.fault;
        end
      end
      sjr_pkg::ST_SURV: begin
        s_q   <= sjr_pkg::sat48(surv_base - DW'(w_q));
        div_q <= DW'(sjr_pkg::sat48(surv_base - DW'(w_q)));
      end
      sjr_pkg::ST_AWAIT: begin
        if (recip_stat.done) begin
          fault_q <= fault_q | recip_stat.fault;
        end
      end
      sjr_pkg::ST_FINISH: begin
        if (out_free) begin
          m_data_q <= {s_q, w_out};
          m_user_q <= fault_q;
          m_last_q <= last_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule

// ----- hdl/sjr_recip.sv -----
// iterative reciprocal unit: 2^(2q) / d, one quotient bit per cycle, saturated to 48 bits
module sjr_recip #(
  parameter int unsigned FRAC_BITS = sjr_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [sjr_pkg::DIV_W-1:0]     divisor_i,
  output logic signed [sjr_pkg::WORD_W-1:0]    quotient_o,
  output sjr_pkg::sjr_recip_stat_t             stat_o
);

  localparam int unsigned TOP_BIT = 2 * FRAC_BITS;
  localparam int unsigned CW      = $clog2(TOP_BIT + 1);

  logic                          busy_q;
  logic                          done_q;
  logic                          zero_q;
  logic                          neg_q;
  logic                          over_q;
  logic [CW-1:0]                 cnt_q;
  logic [sjr_pkg::DIV_W-1:0]     mag_q;
  logic [sjr_pkg::DIV_W-1:0]     rem_q;
  logic [sjr_pkg::QUO_W-1:0]     quo_q;

  logic [sjr_pkg::DIV_W-1:0]     rem_sh;
  logic                          ge;
  logic [sjr_pkg::DIV_W-1:0]     rem_nx;

  // one restoring step: shift in the dividend bit, compare and subtract
  always_comb begin
    rem_sh = {rem_q[sjr_pkg::DIV_W-2:0], (cnt_q == CW'(TOP_BIT))};
    ge     = (rem_sh >= mag_q);
    rem_nx = ge ? (rem_sh - mag_q) : rem_sh;
  end

  // control: busy flag, bit counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (divisor_i == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= CW'(TOP_BIT);
        end
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // datapath: magnitude, partial remainder and quotient bits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      zero_q <= (divisor_i == '0);
      neg_q  <= divisor_i[sjr_pkg::DIV_W-1];
      mag_q  <= divisor_i[sjr_pkg::DIV_W-1] ? sjr_pkg::DIV_W'(-divisor_i)
                                            : sjr_pkg::DIV_W'(divisor_i);
      rem_q  <= '0;
      quo_q  <= '0;
      over_q <= 1'b0;
    end else if (busy_q) begin
      rem_q <= rem_nx;
      quo_q <= {quo_q[sjr_pkg::QUO_W-2:0], ge};
      if (ge && (int'(cnt_q) >= int'(sjr_pkg::QUO_W))) begin
        over_q <= 1'b1;
      end
    end
  end

  // sign and saturation of the finished quotient
  always_comb begin
    if (zero_q) begin
      quotient_o = sjr_pkg::W48_MAX;
    end else if (over_q) begin
      quotient_o = neg_q ? sjr_pkg::W48_MIN : sjr_pkg::W48_MAX;
    end else if (neg_q) begin
      quotient_o = -$signed({1'b0, quo_q});
    end else begin
      quotient_o = $signed({1'b0, quo_q});
    end
  end

  assign stat_o.done  = done_q;
  assign stat_o.fault = done_q & zero_q;

endmodule

// ----- hdl/sjr_checker.sv -----
// port-level checks for the survival jump recursion block, bound to the top level
module sjr_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [sjr_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic                           m_axis_tlast_o
);

  // a held result beat stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result beat dropped while stalled");

  // a held result beat keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result payload changed while stalled");

  // one sample in work at a time
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken again while a sample is in work");

  // the final weight of a set is never negative
  a_last_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> !m_axis_tdata_o[sjr_pkg::WORD_W-1])
    else $error("negative weight on the last sample of a set");

endmodule

bind kmc_survival_jump_recursion_top sjr_checker u_sjr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

// ----- bench/kmc_survival_jump_recursion_top_tb.sv -----
// self-checking testbench for the survival jump recursion block
module kmc_survival_jump_recursion_top_tb;

  localparam int unsigned WORD_W     = sjr_pkg::WORD_W;
  localparam int unsigned CNT_W      = sjr_pkg::CNT_W;
  localparam int unsigned IN_DATA_W  = sjr_pkg::IN_DATA_W;
  localparam int unsigned OUT_DATA_W = sjr_pkg::OUT_DATA_W;
  localparam int unsigned FRAC       = sjr_pkg::FRAC_BITS_DEF;
  localparam longint      ONE_Q      = longint'(1) << FRAC;
  localparam longint      WORD_MAX   = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint      WORD_MIN   = 64'shFFFF_8000_0000_0000;
  localparam int unsigned ITEMS      = 1550;
  localparam int unsigned HOLD_LEN   = 600;
  localparam int unsigned STALL_MAX  = 4000;
  localparam int unsigned IDLE_PCT   = 34;

  // one result beat, fields as they leave the block
  typedef struct packed {
    logic [WORD_W-1:0] weight;
    logic [WORD_W-1:0] surv;
    logic              fault;
    logic              last;
  } jump_result_t;

  logic                   clk_i   = 1'b0;
  logic                   rst_ni  = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [CNT_W-1:0]       cfg_wdata = '0;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata   = '0;
  logic                   s_tuser   = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic                   m_tuser;
  logic                   m_tlast;

  // predictor state
  logic [CNT_W-1:0]       pc_count      = 16'd1;
  logic [CNT_W-1:0]       pc_index      = '0;
  longint                 pc_prev_surv  = 0;
  longint                 pc_censor_sum = 0;

  jump_result_t           jump_expect_q[$];
  jump_result_t           beat_got;
  jump_result_t           beat_want;
  int unsigned            mismatch_count = 0;
  int unsigned            samples_sent   = 0;
  int unsigned            idle_cycles    = 0;
  int unsigned            hold_requests  = 0;
  int unsigned            hold_served    = 0;
  int unsigned            hold_left      = 0;
  bit                     calm           = 1'b0;

  kmc_survival_jump_recursion_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  always #6 clk_i = ~clk_i;

  // clamp to the 48-bit signed range
  function automatic longint clamp_word(input longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  // restoring reciprocal, truncated toward zero, saturated to 48 bits
  function automatic longint reciprocal_q(input longint d);
    longint unsigned mag;
    longint unsigned rem;
    longint unsigned quo;
    bit              neg;
    bit              over;
    if (d == 0) return WORD_MAX;
    neg  = d < 0;
    mag  = neg ? longint'(-d) : d;
    rem  = 0;
    quo  = 0;
    over = 1'b0;
    for (int b = 2 * FRAC; b >= 0; b--) begin
      rem = (rem << 1) | ((b == 2 * FRAC) ? 64'd1 : 64'd0);
      if (rem >= mag) begin
        rem = rem - mag;
        if (b >= 47) over = 1'b1;
        else quo = quo | (64'd1 << b);
      end
    end
    if (over) quo = 64'd1 << 47;
    if (neg) return -longint'(quo);
    if (quo > WORD_MAX) quo = WORD_MAX;
    return longint'(quo);
  endfunction

  // expected beat for one accepted sample, advancing the recursion state
  function automatic void predict_jump(input logic obs, input logic [IN_DATA_W-1:0] value);
    longint       n;
    longint       g;
    longint       d;
    longint       w;
    longint       s;
    bit           fault;
    bit           first;
    bit           last;
    jump_result_t r;
    n     = (pc_count == 0) ? 1 : longint'(pc_count);
    g     = longint'($signed(value)) * (longint'(1) << (FRAC - 16));
    fault = 1'b0;
    first = pc_index == 0;
    last  = longint'(pc_index) >= n - 1;
    if (first) begin
      pc_censor_sum = 0;
      d     = n * ONE_Q - g;
      fault = d == 0;
      w     = reciprocal_q(d);
      s     = clamp_word(ONE_Q - w);
    end else begin
      w = 0;
      if (obs) begin
        d     = n * ONE_Q - g - pc_censor_sum;
        fault = d == 0;
        w     = reciprocal_q(d);
      end
      s = clamp_word(pc_prev_surv - w);
    end
    // censored sample feeds 1/S into the running sum
    if (!obs) begin
      fault         = fault | (s == 0);
      pc_censor_sum = clamp_word(pc_censor_sum + reciprocal_q(s));
    end
    if (last && w < 0) w = 0;
    pc_prev_surv = s;
    pc_index     = last ? '0 : pc_index + 1'b1;
    r.weight = w[WORD_W-1:0];
    r.surv   = s[WORD_W-1:0];
    r.fault  = fault;
    r.last   = last;
    jump_expect_q.insert(jump_expect_q.size(), r);
  endfunction

  // offer one sample until accepted, with random gaps
  task automatic send_sample(input logic obs, input logic [IN_DATA_W-1:0] value);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= obs;
    s_tdata  <= value;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    predict_jump(obs, value);
    samples_sent++;
  endtask

  // write sample_count once the block has drained
  task automatic write_count(input logic [CNT_W-1:0] value);
    s_tvalid <= 1'b0;
    while (jump_expect_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    pc_count  = value;
  endtask

  // count of one after reset, extremes of the constraint value
  task automatic test_default_count();
    send_sample(1'b1, 32'h0000_0000);
    send_sample(1'b0, 32'h0000_0000);   // survival hits zero, sum update divides by zero
    send_sample(1'b1, 32'h7FFF_FFFF);
    send_sample(1'b0, 32'h8000_0000);
    send_sample(1'b1, 32'h0000_FFFF);   // tiny divisor, weight saturates
    send_sample(1'b1, 32'h0001_0001);   // tiny negative divisor, clamped on last
    send_sample(1'b1, 32'h0001_0000);   // zero divisor on a first sample
  endtask

  // short sets: censored first, later observed, negative last weight, zero later divisor
  task automatic test_short_sets();
    write_count(16'd3);
    send_sample(1'b0, 32'h0000_0000);
    send_sample(1'b1, 32'h0000_8000);
    send_sample(1'b1, 32'h7FFF_0000);
    write_count(16'd2);
    send_sample(1'b1, 32'h0000_0000);
    send_sample(1'b1, 32'h0002_0000);
  endtask

  // zero count behaves as a count of one
  task automatic test_zero_count();
    write_count(16'd0);
    send_sample(1'b0, 32'h0000_0000);
    send_sample(1'b1, 32'hFFFF_0000);
  endtask

  // largest count
  task automatic test_full_count();
    write_count(16'hFFFF);
    send_sample(1'b1, 32'h8000_0000);
    send_sample(1'b0, 32'h7FFF_FFFF);
    send_sample(1'b1, 32'hFFFF_FFFF);
  endtask

  // count lowered while the index is past the new end of set
  task automatic test_count_lowered();
    write_count(16'd6);
    send_sample(1'b1, 32'h0000_4000);
    send_sample(1'b0, 32'hFFFF_C000);
    send_sample(1'b1, 32'h0001_0000);
    send_sample(1'b0, 32'h0000_0000);
    write_count(16'd2);
    send_sample(1'b1, 32'h0000_2000);
    send_sample(1'b1, 32'h0000_0000);
    send_sample(1'b0, 32'hFFFF_0000);
  endtask

  // receiver holds off for a long stretch while samples keep coming
  task automatic test_receiver_hold();
    write_count(16'd4);
    calm = 1'b1;
    hold_requests++;
    repeat (12) send_sample(1'($urandom_range(1)),
                            $urandom_range(32'h0002_0000) - 32'h0001_0000);
    calm = 1'b0;
  endtask

  // random phases of mostly well-formed sets with some noise
  task automatic test_random_sets();
    int unsigned      phase;
    int unsigned      roll;
    int unsigned      n;
    int unsigned      burst;
    logic [CNT_W-1:0] count;
    logic             obs;
    logic [31:0]      cv;
    phase = 0;
    while (samples_sent < ITEMS) begin
      roll = $urandom_range(99);
      if (roll < 70) count = CNT_W'($urandom_range(6, 1));
      else if (roll < 80) count = CNT_W'($urandom_range(40, 7));
      else if (roll < 85) count = '0;
      else if (roll < 90) count = 16'hFFFF;
      else count = CNT_W'($urandom);
      write_count(count);
      n     = (count == 0) ? 1 : count;
      burst = (n <= 40) ? $urandom_range(3 * n + 2, 1) : $urandom_range(20, 1);
      // a run of phases with no idling on either side
      calm  = (phase >= 20) && (phase < 30);
      repeat (burst) begin
        roll = $urandom_range(99);
        obs  = $urandom_range(99) < 60;
        if (roll < 12) begin
          cv = $urandom;
        end else if (roll < 16 && pc_index == 0) begin
          cv = n << 16;
        end else if (roll < 20 && pc_index == 0) begin
          cv  = (n - 1) << 16;
          obs = 1'b0;
        end else begin
          cv = $urandom_range(n << 16) - (n << 15);
        end
        send_sample(obs, cv);
      end
      phase++;
    end
    calm = 1'b0;
  endtask

  // receiver: random stalls, plus the long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_LEN;
      m_tready    <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      beat_got = {m_tdata[WORD_W-1:0], m_tdata[2*WORD_W-1:WORD_W], m_tuser, m_tlast};
      if (jump_expect_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected beat: w=%h s=%h f=%b l=%b",
                   beat_got.weight, beat_got.surv, beat_got.fault, beat_got.last);
      end else begin
        beat_want = jump_expect_q.pop_front();
        if (beat_got !== beat_want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("beat mismatch: want w=%h s=%h f=%b l=%b, got w=%h s=%h f=%b l=%b",
                     beat_want.weight, beat_want.surv, beat_want.fault, beat_want.last,
                     beat_got.weight, beat_got.surv, beat_got.fault, beat_got.last);
        end
      end
    end
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_MAX) begin
        $display("kmc_survival_jump_recursion_top_tb NOT OK");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_count();
    test_short_sets();
    test_zero_count();
    test_full_count();
    test_count_lowered();
    test_receiver_hold();
    test_random_sets();
    s_tvalid <= 1'b0;
    while (jump_expect_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("kmc_survival_jump_recursion_top_tb OK");
    end else begin
      $display("kmc_survival_jump_recursion_top_tb NOT OK");
    end
    $finish;
  end

endmodule
